// ===== rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table package
// Shared constants and codes for the bounded integer set table block.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    // Number of entries the store can hold.
    localparam int DEPTH = 16;

    // Width of a slot index into the store, at least one bit.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Width of the occupancy count, which must also hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the item and result beats.
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    // Beat widths, padded up to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0
    } reg_index_t;

    // Operation codes. The unused code behaves as a lookup.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_t;

endpackage

`default_nettype wire

// ===== rtl/bounded_integer_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table
// Unordered set of signed 32-bit values kept in a packed store with a count.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries an operation (lookup, add or
// remove) and a value. The block scans the occupied slots one per cycle
// through a single comparator, then performs the update and posts one result
// beat on the m_ channel with found, slot, changed and the new count.
// An add appends the value when it is absent and the count is below the
// configured capacity (saturated at DEPTH). A remove copies the last entry
// into the freed slot.
// A lookup or add passes through the scan, update and done steps, and a
// successful remove adds a move step after the update. With a full store
// the scan is the longest step; the scan loop through the one comparator
// and the single store read port set the time each item takes.
// s_tready is high only while the block is waiting for an item; a finished
// result sits in the output register, so the next item may be taken while
// the receiver stalls. A further result waits in its final step until the
// output register has been emptied.
// Reset empties the set and restores capacity to 16. The stored values are
// not cleared. The capacity register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_integer_set_table_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Item beat.
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // [1:0] func, [33:2] value, [39:34] zero
    input  wire logic [bis_pkg::S_DATA_W-1:0]  s_tdata,
    // Result beat.
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [0] found, [4:1] slot, [5] changed, [10:6] count, [15:11] zero
    output      logic [bis_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bis_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bis_pkg::PDATA_W-1:0]   pwdata,
    output      logic [bis_pkg::PDATA_W-1:0]   prdata,
    output      logic                          pready
);
    import bis_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MOVE,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                found_reg;
    logic                changed_reg;
    logic [CAP_W-1:0]    capacity_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Entry store with one write port and one registered read port.
    logic [VALUE_W-1:0]  mem [DEPTH];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;

    logic                s_accept;
    logic                cfg_write;
    logic                in_range;
    logic                hit;
    logic                room;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    occ_dec;
    logic                out_free;
    logic [31:0]         slot_ext;
    logic [31:0]         count_ext;
    logic [31:0]         cap_ext;
    logic [31:0]         occ_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign occ_dec  = occ_reg - CNT_W'(1);
    assign in_range = (idx_reg < occ_reg);
    assign hit      = (rd_data_reg == value_reg);
    assign cap_ext  = 32'(capacity_reg);
    assign occ_ext  = 32'(occ_reg);
    assign room     = (occ_ext < cap_ext) && (occ_ext < 32'(DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;

    // Read address: first slot on accept, the next slot during the scan and
    // the last occupied slot while a remove prepares its move.
    always_comb begin
        case (state_reg)
            ST_IDLE:   rd_addr = '0;
            ST_SCAN:   rd_addr = idx_inc[IDX_W-1:0];
            ST_UPDATE: rd_addr = occ_dec[IDX_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = occ_reg[IDX_W-1:0];
        mem_wdata = value_reg;
        if (state_reg == ST_UPDATE && func_reg == FUNC_ADD && !found_reg && room) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_MOVE) begin
            mem_we    = 1'b1;
            mem_waddr = slot_reg;
            mem_wdata = rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign slot_ext  = 32'(slot_reg);
    assign count_ext = 32'(occ_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            capacity_reg <= CAPACITY_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == REG_CAPACITY) begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end
            // A beat taken while the next result is posted is replaced below.
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        func_reg    <= s_tdata[FUNC_W-1:0];
                        value_reg   <= s_tdata[FUNC_W +: VALUE_W];
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        slot_reg    <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!in_range) begin
                        state_reg <= ST_UPDATE;
                    end else if (hit) begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_reg[IDX_W-1:0];
                        state_reg <= ST_UPDATE;
                    end else begin
                        idx_reg <= idx_inc;
                    end
                end
                ST_UPDATE: begin
                    if (func_reg == FUNC_ADD && !found_reg && room) begin
                        occ_reg     <= occ_reg + CNT_W'(1);
                        changed_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end else if (func_reg == FUNC_REMOVE && found_reg) begin
                        // The last entry is being read for the move.
                        occ_reg     <= occ_dec;
                        changed_reg <= 1'b1;
                        state_reg   <= ST_MOVE;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MOVE: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b0, count_ext[COUNT_W-1:0], changed_reg,
                                         slot_ext[SLOT_W-1:0], found_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bis_checker.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table checker
// Port-level assertions on the set table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bis_pkg::M_DATA_W-1:0]  m_tdata
);
    import bis_pkg::*;

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another was in work");

    // A miss always reports slot zero.
    a_miss_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("slot nonzero on a miss");

    // The count never exceeds the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[10:6]) <= 32'(DEPTH))
        else $error("count above depth");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

endmodule

bind bounded_integer_set_table_unit bis_checker u_bis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/bounded_integer_set_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Bounded integer set table testbench
// Drives lookup, add and remove beats into the set table through a queued
// driver, predicts every result from a local copy of the set and its capacity,
// and checks each result beat field by field in order of arrival. Capacity is
// rewritten between phases over APB and read back, covering zero, values
// below the occupancy and values above the store depth.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_unit_tb;

    import bis_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_OPS     = 200;
    localparam int POOL_SIZE     = 20;

    // The spare operation code, which the block treats as a lookup.
    localparam func_t FUNC_SPARE = func_t'(2'd3);

    localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        func_t              func;
    } set_op_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               changed;
        logic [SLOT_W-1:0]  slot;
        logic               found;
    } set_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Local copy of the set as the block should hold it.
    logic [VALUE_W-1:0]   model_entries [DEPTH];
    logic [COUNT_W-1:0]   model_count    = '0;
    logic [CAP_W-1:0]     model_capacity = CAPACITY_RESET;

    set_op_t              pending_ops [$];
    set_result_t          awaited_results [$];

    int                   mismatch_count = 0;
    int                   results_seen   = 0;
    int                   tx_gap         = 0;
    int                   rx_stall       = 0;
    int                   holds_asked    = 0;
    int                   holds_done     = 0;
    bit                   tx_steady      = 1'b1;
    bit                   rx_steady      = 1'b1;

    bounded_integer_set_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Applies one operation to the local set and returns the result it yields.
    function automatic set_result_t set_table_apply(set_op_t op);
        set_result_t      r;
        int               pos;
        logic [CAP_W-1:0] limit;
        pos = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos < 0 && i < model_count && model_entries[i] == op.value) pos = i;
        end
        limit     = (model_capacity < DEPTH) ? model_capacity : CAP_W'(DEPTH);
        r.found   = (pos >= 0);
        r.slot    = r.found ? SLOT_W'(pos) : '0;
        r.changed = 1'b0;
        if (op.func == FUNC_ADD) begin
            if (!r.found && model_count < limit) begin
                model_entries[model_count] = op.value;
                model_count++;
                r.changed = 1'b1;
            end
        end else if (op.func == FUNC_REMOVE) begin
            if (r.found) begin
                // The last entry fills the hole left by the removed one.
                model_count--;
                model_entries[pos] = model_entries[model_count];
                r.changed = 1'b1;
            end
        end
        r.count = model_count;
        return r;
    endfunction

    // Item driver: presents queued beats, with random gaps between them unless steady.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                s_tdata  <= S_DATA_W'(pending_ops.pop_front());
                s_tvalid <= 1'b1;
                tx_gap   <= tx_steady ? 0 : idle_length();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls unless steady, plus a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            rx_stall   <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady) rx_stall <= idle_length();
        end
    end

    // Monitor: tracks capacity writes, predicts on each item beat and checks
    // each result beat against the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        set_result_t got;
        set_result_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
                model_capacity = pwdata[CAP_W-1:0];
            if (m_tvalid && m_tready) begin
                got = set_result_t'(m_tdata[$bits(set_result_t)-1:0]);
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with none expected: %h",
                                         results_seen, m_tdata));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.changed !== want.changed || got.count !== want.count)
                        flag_error($sformatf({"result %0d: expected found=%0b slot=%0d ",
                            "changed=%0b count=%0d, got found=%0b slot=%0d changed=%0b ",
                            "count=%0d"}, results_seen, want.found, want.slot,
                            want.changed, want.count, got.found, got.slot, got.changed,
                            got.count));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(
                    set_table_apply(set_op_t'(s_tdata[$bits(set_op_t)-1:0])));
        end
    end

    task automatic queue_op(func_t f, logic [VALUE_W-1:0] v);
        set_op_t op;
        op.func  = f;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // Waits until every queued beat has gone in and every result has come out.
    task automatic settle();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the capacity register once the block is idle, then reads it back.
    task automatic change_capacity(logic [CAP_W-1:0] cap);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= PDATA_W'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== PDATA_W'(cap))
            flag_error($sformatf("capacity read back: expected %0d, got %h", cap, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly draws from a small pool so that adds meet present values and the
    // store fills; the rest are fully random values.
    task automatic queue_random_ops(int n);
        logic [VALUE_W-1:0] pool [POOL_SIZE];
        logic [VALUE_W-1:0] v;
        func_t              f;
        int                 add_w;
        int                 rem_w;
        int                 r;
        pool[0] = MOST_NEG;
        pool[1] = MOST_POS;
        pool[2] = '0;
        pool[3] = ALL_ONES;
        for (int k = 4; k < POOL_SIZE; k++)
            pool[k] = (k < 10) ? VALUE_W'($urandom_range(0, 40)) - 32'd20 : $urandom;
        add_w = $urandom_range(30, 60);
        rem_w = $urandom_range(15, 35);
        repeat (n) begin
            r = $urandom_range(0, 99);
            f = (r < 5) ? FUNC_SPARE :
                (r < 5 + add_w) ? FUNC_ADD :
                (r < 5 + add_w + rem_w) ? FUNC_REMOVE : FUNC_LOOKUP;
            v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_op(f, v);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps [9];
        logic [CAP_W-1:0] cap;
        caps = '{5'd31, 5'd16, 5'd3, 5'd0, 5'd1, 5'd17, 5'd8, 5'd0, 5'd16};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty set, extreme values, duplicates, the spare code and removes
        // that pull the last entry into the first slot.
        queue_op(FUNC_LOOKUP, '0);
        queue_op(FUNC_REMOVE, MOST_POS);
        queue_op(FUNC_ADD, MOST_NEG);
        queue_op(FUNC_ADD, MOST_POS);
        queue_op(FUNC_ADD, '0);
        queue_op(FUNC_ADD, ALL_ONES);
        queue_op(FUNC_ADD, MOST_POS);
        queue_op(FUNC_LOOKUP, ALL_ONES);
        queue_op(FUNC_SPARE, MOST_NEG);
        queue_op(FUNC_SPARE, 32'h1234_5678);
        queue_op(FUNC_REMOVE, MOST_NEG);
        queue_op(FUNC_LOOKUP, ALL_ONES);
        queue_op(FUNC_REMOVE, 32'h5555_5555);
        queue_op(FUNC_REMOVE, ALL_ONES);
        queue_op(FUNC_REMOVE, MOST_POS);

        // A full set at a small capacity, then a capacity below the occupancy.
        change_capacity(5'd2);
        queue_op(FUNC_ADD, 32'hAAAA_AAAA);
        queue_op(FUNC_ADD, 32'h5555_5555);
        queue_op(FUNC_LOOKUP, 32'h5555_5555);
        change_capacity(5'd0);
        queue_op(FUNC_ADD, 32'h0F0F_0F0F);
        queue_op(FUNC_REMOVE, '0);
        queue_op(FUNC_LOOKUP, 32'hAAAA_AAAA);

        for (int k = 0; k < 9; k++) begin
            cap = (k == 7) ? CAP_W'($urandom_range(0, 31)) : caps[k];
            change_capacity(cap);
            tx_steady = (k % 3 == 2) || (k == 1);
            rx_steady = (k % 4 == 3);
            queue_random_ops(PHASE_OPS);
            // The receiver holds off while the sender keeps offering beats.
            if (k == 1) holds_asked++;
        end

        settle();
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bis_pkg.sv
rtl/bounded_integer_set_table_unit.sv
rtl/bis_checker.sv
dv/bounded_integer_set_table_unit_tb.sv
